// ===== rtl/core/scancode_to_ascii_fifo_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the scancode-to-ASCII FIFO
// Shared clocked property wrappers, clocked on i_clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_FIFO_TOP_MACROS_SVH
`define SCANCODE_TO_ASCII_FIFO_TOP_MACROS_SVH

// Same-cycle implication
`define SCTA_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |-> (post)) else $error(msg);

// Next-cycle implication
`define SCTA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/scta_pkg.sv =====
// ----------------------------------------------------------------------------
// scta_pkg
// Types, sizes and key tables for the scancode-to-ASCII FIFO.
// ----------------------------------------------------------------------------
package scta_pkg;

    localparam int FifoDepth = 256;
    localparam int PtrW      = $clog2(FifoDepth);
    localparam int CharW     = 7;
    localparam int MapLen    = 58;
    localparam int MapW      = $clog2(MapLen);

    localparam logic [7:0] RelBit   = 8'h80;
    localparam logic [6:0] LShift   = 7'h2A;
    localparam logic [6:0] RShift   = 7'h36;
    localparam logic [6:0] CapsLock = 7'h3A;

    typedef logic [PtrW-1:0]  t_ptr;
    typedef logic [CharW-1:0] t_char;

    typedef enum logic [1:0] {
        FuncScan  = 2'd0,
        FuncRead  = 2'd1,
        FuncClear = 2'd2
    } t_func;

    // Translator result toward the FIFO
    typedef struct packed {
        logic  enq;
        t_char ch;
    } t_key_out;

    // Status carried with a beat down the output pipe
    typedef struct packed {
        logic cv;
        logic hi;
    } t_res;

    // Unshifted set-1 map, codes 0 to 57
    localparam t_char PlainMap [MapLen] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    // Shifted set-1 map, codes 0 to 57
    localparam t_char UpperMap [MapLen] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    // Advance a ring pointer, wrapping at the FIFO depth
    function automatic t_ptr ring_next(input t_ptr p);
        return (p == PtrW'(FifoDepth - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ===== rtl/core/scancode_to_ascii_fifo_top.sv =====
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_top
// Set-1 scancode to ASCII translator with a ring character FIFO.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Fields
//  --------+-----------+----------------------+---------------------------------
//  input   | in        | i_valid / o_stall    | i_func, i_scancode
//  output  | out       | o_valid / i_stall    | o_read_char, o_char_valid,
//          |           |                      | o_has_input
//
//  One beat per cycle while o_stall is low; each beat gives one result, passing
//  through the RAM read register, then the output register.
//  Pointers and modifier flags update at the accepting edge, so the next beat
//  sees them at once; the RAM has one write and one read port.
//  Reset is synchronous, active low; the FIFO RAM is not cleared.
//  o_stall rises only when the RAM stage and output register are full and i_stall is high.
// ----------------------------------------------------------------------------
`include "scancode_to_ascii_fifo_top_macros.svh"

module scancode_to_ascii_fifo_top
    import scta_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_func,
    input  logic [7:0] i_scancode,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_read_char,
    output logic       o_char_valid,
    output logic       o_has_input
);

    t_func    func;
    logic     accept;
    t_key_out key;
    t_ptr     r_rd_ptr;
    t_ptr     r_wr_ptr;
    t_ptr     n_rd_ptr;
    t_ptr     n_wr_ptr;
    t_ptr     rd_nxt;
    t_ptr     wr_nxt;
    logic     ram_we;
    logic     ram_re;
    logic     res_cv;
    t_char    ram_q;
    logic     r_a_valid;
    t_res     r_a_res;
    logic     b_free;
    logic     b_load;

    assign func   = t_func'(i_func);
    assign b_load = r_a_valid && b_free;
    assign o_stall = r_a_valid && !b_free;
    assign accept = i_valid && !o_stall;
    assign rd_nxt = ring_next(r_rd_ptr);
    assign wr_nxt = ring_next(r_wr_ptr);

    // Translate scancodes
    scta_keymap u_keymap (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (accept && (func == FuncScan)),
        .i_scancode (i_scancode),
        .o_key      (key)
    );

    // Decide push, pop or clear
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        res_cv   = 1'b0;
        if (accept) begin
            case (func)
                FuncScan: begin
                    if (key.enq && (wr_nxt != r_rd_ptr)) begin
                        ram_we   = 1'b1;
                        n_wr_ptr = wr_nxt;
                    end
                end
                FuncRead: begin
                    if (r_rd_ptr != r_wr_ptr) begin
                        ram_re   = 1'b1;
                        res_cv   = 1'b1;
                        n_rd_ptr = rd_nxt;
                    end
                end
                FuncClear: begin
                    n_rd_ptr = '0;
                    n_wr_ptr = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
        end
    end

    // Character store; a read never targets the entry being written
    scta_char_ram #(
        .Depth (FifoDepth),
        .Width (CharW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (key.ch),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_q)
    );

    // RAM read stage: carry status alongside the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (b_load) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_res.cv <= res_cv;
            r_a_res.hi <= (n_rd_ptr != n_wr_ptr);
        end
    end

    // Output register
    scta_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (b_load),
        .i_res        (r_a_res),
        .i_q          (ram_q),
        .i_stall      (i_stall),
        .o_free       (b_free),
        .o_valid      (o_valid),
        .o_read_char  (o_read_char),
        .o_char_valid (o_char_valid),
        .o_has_input  (o_has_input)
    );

    `SCTA_ASSERT_NOW(a_no_push_when_full, ram_we, wr_nxt != r_rd_ptr, "push into full FIFO")
    `SCTA_ASSERT_NOW(a_no_pop_when_empty, ram_re, r_rd_ptr != r_wr_ptr, "pop from empty FIFO")
    `SCTA_ASSERT_NEXT(a_accept_fills_stage, accept, r_a_valid, "accepted beat lost")

endmodule

// ===== rtl/core/scta_char_ram.sv =====
// ----------------------------------------------------------------------------
// scta_char_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module scta_char_ram #(
    parameter int Depth = 256,
    parameter int Width = 7
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/scta_keymap.sv =====
// ----------------------------------------------------------------------------
// scta_keymap
// Tracks shift and caps lock and turns set-1 make codes into ASCII.
// ----------------------------------------------------------------------------
module scta_keymap
    import scta_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  logic [7:0] i_scancode,
    output t_key_out o_key
);

    logic       r_shift;
    logic       r_caps;
    logic       n_shift;
    logic       n_caps;
    logic       rel;
    logic [6:0] code;
    logic       is_shift;
    logic       in_map;
    logic [MapW-1:0] idx;
    t_char      ch;

    // Decode the byte
    assign rel      = (i_scancode & RelBit) != 8'h00;
    assign code     = i_scancode[6:0];
    assign is_shift = (code == LShift) || (code == RShift);
    assign in_map   = !rel && (i_scancode < 8'(MapLen));
    assign idx      = i_scancode[MapW-1:0];

    // Look up with the current modifier state
    assign ch = (r_shift ^ r_caps) ? UpperMap[idx] : PlainMap[idx];

    assign o_key.enq = i_take && in_map && (ch != '0);
    assign o_key.ch  = ch;

    // Update modifier flags
    always_comb begin
        n_shift = r_shift;
        n_caps  = r_caps;
        if (i_take) begin
            if (rel) begin
                if (is_shift) begin
                    n_shift = 1'b0;
                end
            end else if (is_shift) begin
                n_shift = 1'b1;
            end else if (code == CapsLock) begin
                n_caps = !r_caps;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
        end else begin
            r_shift <= n_shift;
            r_caps  <= n_caps;
        end
    end

endmodule

// ===== rtl/core/scta_out_reg.sv =====
// ----------------------------------------------------------------------------
// scta_out_reg
// Output register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
`include "scancode_to_ascii_fifo_top_macros.svh"

module scta_out_reg
    import scta_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_res  i_res,
    input  t_char i_q,
    input  logic  i_stall,
    output logic  o_free,
    output logic  o_valid,
    output t_char o_read_char,
    output logic  o_char_valid,
    output logic  o_has_input
);

    logic  r_valid;
    t_char r_char;
    logic  r_cv;
    logic  r_hi;

    assign o_free = !r_valid || !i_stall;

    // Hold valid while stalled, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload, masking the RAM word unless a character was popped
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_char <= i_res.cv ? i_q : '0;
            r_cv   <= i_res.cv;
            r_hi   <= i_res.hi;
        end
    end

    assign o_valid      = r_valid;
    assign o_read_char  = r_char;
    assign o_char_valid = r_cv;
    assign o_has_input  = r_hi;

    `SCTA_ASSERT_NOW(a_load_when_free, i_load, o_free, "load into a busy output register")
    `SCTA_ASSERT_NEXT(a_load_sets_valid, i_load, r_valid, "loaded beat lost")

endmodule
